### rtl/core/rtp_pkg.sv
package rtp_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LANES     = 3;
  localparam int ROW_W     = 7;
  localparam int COLUMN_W  = 9;
  localparam int KIND_W    = 3;
  localparam int SCALE_W   = 16;
  localparam int QUOT_W    = 6;
  localparam int NUM_W     = 22;

  localparam logic [ROW_W-1:0] MID_ROW = 7'd61;

  localparam logic [KIND_W-1:0] KIND_ERASE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GRID  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CH0   = 3'd2;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_AUTO_RANGE     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_ENABLE = 1'd1;

  localparam logic                 AUTO_RANGE_RESET     = 1'b1;
  localparam logic [LANES-1:0]     CHANNEL_ENABLE_RESET = 3'd3;
  localparam logic [SCALE_W-1:0]   SCALE_RESET [LANES] = '{16'd60, 16'd50, 16'd40};

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t [LANES-1:0] sample;
  } item_t;

endpackage

### rtl/core/rtp_ram.sv
module rtp_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/rtp_fifo.sv
module rtp_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rtp_pkg::item_t push_item,
  input  logic          pop,
  output rtp_pkg::item_t head_item,
  output logic          q_valid,
  output logic          q_full
);

  rtp_pkg::item_t                     slot_r [rtp_pkg::QUEUE_DEPTH];
  logic [rtp_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [rtp_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [rtp_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;

  assign q_valid   = (cnt_r != '0);
  assign q_full    = (cnt_r == rtp_pkg::QCNT_W'(rtp_pkg::QUEUE_DEPTH));
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == rtp_pkg::QPTR_W'(rtp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == rtp_pkg::QPTR_W'(rtp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/core/rtp_front.sv
module rtp_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [47:0]                   in_tdata,
  input  logic [rtp_pkg::LANES-1:0]     channel_enable,
  input  logic                          clearing,
  input  logic                          q_full,
  output logic                          push,
  output rtp_pkg::item_t                push_item
);

  assign in_tready = !clearing && !q_full;
  assign push      = in_tvalid && in_tready;

  // Disabled channels enter the queue as a zero sample.
  always_comb begin
    for (int i = 0; i < rtp_pkg::LANES; i++) begin
      push_item.sample[i] = channel_enable[i] ? in_tdata[rtp_pkg::SAMPLE_W*i +: rtp_pkg::SAMPLE_W]
                                              : '0;
    end
  end

endmodule

### rtl/core/rtp_back.sv
module rtp_back #(
  parameter int SCREEN_COLUMNS = 256,
  parameter int CHANNELS       = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            auto_range,
  input  logic                            q_valid,
  input  rtp_pkg::item_t                  head_item,
  output logic                            pop,
  output logic                            clearing,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rtp_pkg::COLUMN_W-1:0]    out_column,
  output logic [rtp_pkg::ROW_W-1:0]       out_row,
  output logic [rtp_pkg::KIND_W-1:0]      out_kind,
  output logic                            out_last
);

  localparam int DEPTH  = SCREEN_COLUMNS * CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = $clog2(SCREEN_COLUMNS);
  localparam int CW     = POS_W + 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_ERASE = 7'b0001000,
    ST_PREP  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DRAW  = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [ADDR_W-1:0]               clr_addr_r, clr_addr_nxt;
  logic [POS_W-1:0]                pos_r, pos_nxt;
  logic [CH_W-1:0]                 ch_r, ch_nxt;
  logic [rtp_pkg::SCALE_W-1:0]     scale_r [CHANNELS];
  logic [rtp_pkg::SCALE_W-1:0]     scale_nxt [CHANNELS];
  logic [rtp_pkg::NUM_W-1:0]       num_r, num_nxt;
  logic [rtp_pkg::SCALE_W-1:0]     den_r, den_nxt;
  logic                            neg_r, neg_nxt;
  logic [rtp_pkg::QUOT_W-1:0]      quot_r, quot_nxt;
  logic [2:0]                      bit_r, bit_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [rtp_pkg::COLUMN_W-1:0]    out_column_r, out_column_nxt;
  logic [rtp_pkg::ROW_W-1:0]       out_row_r, out_row_nxt;
  logic [rtp_pkg::KIND_W-1:0]      out_kind_r, out_kind_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            ram_we;
  logic [ADDR_W-1:0]               ram_waddr;
  logic [rtp_pkg::ROW_W-1:0]       ram_wdata;
  logic [ADDR_W-1:0]               slot;
  logic [rtp_pkg::ROW_W-1:0]       old_row;

  logic [CW-1:0]                   col;
  logic                            out_free;
  logic                            last_ch;
  rtp_pkg::sample_t                s_cur;
  logic [rtp_pkg::SCALE_W-1:0]     mag;
  logic [rtp_pkg::SCALE_W-1:0]     clamp;
  logic                            need_erase;
  logic [rtp_pkg::NUM_W-1:0]       den_sh;
  logic [rtp_pkg::ROW_W-1:0]       row_new;

  rtp_ram #(
    .WIDTH (rtp_pkg::ROW_W),
    .DEPTH (DEPTH)
  ) u_trace_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (slot),
    .rd_data (old_row)
  );

  assign clearing   = (state_r == ST_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_column = out_column_r;
  assign out_row    = out_row_r;
  assign out_kind   = out_kind_r;
  assign out_last   = out_last_r;

  assign slot     = ADDR_W'(ch_r) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(pos_r);
  assign col      = CW'(pos_r) + CW'(1);
  assign out_free = !out_valid_r || out_ready;
  assign last_ch  = (ch_r == CH_W'(CHANNELS - 1));
  assign s_cur    = $signed(head_item.sample[2'(ch_r)]);
  assign mag      = s_cur[rtp_pkg::SAMPLE_W-1] ? rtp_pkg::SCALE_W'(~s_cur + 1'b1)
                                               : rtp_pkg::SCALE_W'(s_cur);
  assign clamp    = (mag > scale_r[ch_r]) ? scale_r[ch_r] : mag;
  assign need_erase = (old_row != '0) &&
                      ((old_row != rtp_pkg::MID_ROW) || (col[1:0] == 2'd0) ||
                       (col[1:0] == 2'd1));
  assign den_sh   = rtp_pkg::NUM_W'(den_r) << bit_r;
  assign row_new  = neg_r ? rtp_pkg::MID_ROW + rtp_pkg::ROW_W'(quot_r)
                          : rtp_pkg::MID_ROW - rtp_pkg::ROW_W'(quot_r);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    pos_nxt        = pos_r;
    ch_nxt         = ch_r;
    scale_nxt      = scale_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    neg_nxt        = neg_r;
    quot_nxt       = quot_r;
    bit_nxt        = bit_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_column_nxt = out_column_r;
    out_row_nxt    = out_row_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = slot;
    ram_wdata      = row_new;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          ch_nxt    = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_ERASE;
      end
      ST_ERASE: begin
        if (!need_erase || out_free) begin
          if (need_erase) begin
            out_valid_nxt  = 1'b1;
            out_column_nxt = rtp_pkg::COLUMN_W'(col);
            out_row_nxt    = old_row;
            out_kind_nxt   = (old_row == rtp_pkg::MID_ROW) ? rtp_pkg::KIND_GRID
                                                           : rtp_pkg::KIND_ERASE;
            out_last_nxt   = 1'b0;
          end
          if (auto_range && (mag > scale_r[ch_r])) begin
            scale_nxt[ch_r] = mag;
          end
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        num_nxt   = (rtp_pkg::NUM_W'(clamp) << 6) - (rtp_pkg::NUM_W'(clamp) << 2);
        den_nxt   = scale_r[ch_r];
        neg_nxt   = s_cur[rtp_pkg::SAMPLE_W-1];
        quot_nxt  = '0;
        bit_nxt   = 3'(rtp_pkg::QUOT_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (num_r >= den_sh) begin
          num_nxt          = num_r - den_sh;
          quot_nxt[bit_r]  = 1'b1;
        end
        if (bit_r == '0) begin
          state_nxt = ST_DRAW;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      ST_DRAW: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_column_nxt = rtp_pkg::COLUMN_W'(col);
          out_row_nxt    = row_new;
          out_kind_nxt   = rtp_pkg::KIND_CH0 + rtp_pkg::KIND_W'(ch_r);
          out_last_nxt   = last_ch;
          ram_we         = 1'b1;
          if (last_ch) begin
            pop       = 1'b1;
            pos_nxt   = (pos_r == POS_W'(SCREEN_COLUMNS - 1)) ? '0 : pos_r + 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      pos_r       <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        scale_r[i] <= rtp_pkg::SCALE_RESET[i];
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pos_r       <= pos_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      scale_r     <= scale_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    neg_r        <= neg_nxt;
    quot_r       <= quot_nxt;
    bit_r        <= bit_nxt;
    out_column_r <= out_column_nxt;
    out_row_r    <= out_row_nxt;
    out_kind_r   <= out_kind_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

### rtl/core/rolling_trace_plotter.sv
// Scrolling oscilloscope trace writer.
// Each input beat on in_* carries one signed 16-bit sample for each of up to three
// channels. For every beat the block emits, per channel, an optional erase of the
// pixel stored at the current column (black, or white on dotted midline columns)
// followed by a draw of the new sample in the channel's colour; the last draw
// beat of an item has out_tlast high. The column then advances and wraps.
// The cfg_* port writes auto_range (index 0) and channel_enable (index 1); write
// it only while the block is idle.
// Accepted beats wait in a two-entry queue; the back end handles one item at a
// time and, for each channel, steps through a trace memory read, an erase slot,
// a scaling step, the shared restoring divider and a draw slot.
// After reset the trace memory is cleared one entry a cycle, covering all
// SCREEN_COLUMNS * CHANNELS entries; in_tready stays low meanwhile.
// When the receiver stalls, the result waits in the output register, the back end
// holds, and the queue keeps accepting until it is full.
module rolling_trace_plotter #(
  parameter int SCREEN_COLUMNS = 256,
  parameter int CHANNELS       = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // sample_a, sample_b, sample_c
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pixel_column, pixel_row
  output logic [2:0]  out_tuser,  // pixel_kind
  output logic        out_tlast,  // last_pixel
  input  logic        cfg_wr_en,
  input  logic [rtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rtp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                          auto_range_r;
  logic [rtp_pkg::LANES-1:0]     channel_enable_r;
  logic                          clearing;
  logic                          q_full;
  logic                          q_valid;
  logic                          push;
  logic                          pop;
  rtp_pkg::item_t                push_item;
  rtp_pkg::item_t                head_item;
  logic [rtp_pkg::COLUMN_W-1:0]  pixel_column;
  logic [rtp_pkg::ROW_W-1:0]     pixel_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_range_r     <= rtp_pkg::AUTO_RANGE_RESET;
      channel_enable_r <= rtp_pkg::CHANNEL_ENABLE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rtp_pkg::REG_AUTO_RANGE:     auto_range_r     <= cfg_data[0];
        rtp_pkg::REG_CHANNEL_ENABLE: channel_enable_r <= cfg_data;
      endcase
    end
  end

  rtp_front u_front (
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .channel_enable (channel_enable_r),
    .clearing       (clearing),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  rtp_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_valid   (q_valid),
    .q_full    (q_full)
  );

  rtp_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .CHANNELS       (CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .auto_range (auto_range_r),
    .q_valid    (q_valid),
    .head_item  (head_item),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_column (pixel_column),
    .out_row    (pixel_row),
    .out_kind   (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {pixel_row, pixel_column};

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("input accepted during trace memory clear");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pixel_row >= 7'd1) && (pixel_row <= 7'd121))
    else $error("pixel row out of range");

  a_grid_on_midline: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == rtp_pkg::KIND_GRID) |-> (pixel_row == rtp_pkg::MID_ROW))
    else $error("grid pixel off the midline");

  a_last_is_final_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == rtp_pkg::KIND_CH0 + 3'(CHANNELS - 1)))
    else $error("last beat is not the final channel draw");

endmodule
